/* sv/rmj_pkg.sv */
// Shared widths, constants and pipeline item types of the radar measurement Jacobian.
package rmj_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int C1_W      = 64;
	localparam int REM_W     = 34;
	localparam int C3_W      = 96;
	localparam int NUM_W     = 128;
	localparam int QB        = 33;
	localparam int SQ_STEPS  = 32;
	localparam int LANES     = 6;

	localparam int L_RDX = 0;
	localparam int L_RDY = 1;
	localparam int L_BDX = 2;
	localparam int L_BDY = 3;
	localparam int L_TDX = 4;
	localparam int L_TDY = 5;

	localparam logic [DATA_W-1:0] RANGE_SQ_RESET = 32'd42950;

	// Substitute state near the origin, rounded to nearest at FRAC_BITS.
	localparam logic [DATA_W-1:0] FB_MILLI =
		DATA_W'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
	localparam logic [DATA_W-1:0] FB_CENTI =
		DATA_W'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
	localparam logic [C1_W-1:0] FB_C1 =
		C1_W'(FB_MILLI) * C1_W'(FB_MILLI) + C1_W'(FB_CENTI) * C1_W'(FB_CENTI);
	// With vx = vy = px the cross term reduces to px * (py - px).
	localparam logic [C1_W-1:0] FB_AD = C1_W'(FB_MILLI) *
		C1_W'((FB_CENTI >= FB_MILLI) ? (FB_CENTI - FB_MILLI) : (FB_MILLI - FB_CENTI));
	localparam logic FB_PD = (FB_MILLI != 0) && (FB_CENTI > FB_MILLI);
	localparam logic FB_ND = (FB_MILLI != 0) && (FB_CENTI < FB_MILLI);

	typedef struct packed {
		logic [DATA_W-1:0] apx;
		logic [DATA_W-1:0] apy;
		logic              npx;
		logic              npy;
		logic [C1_W-1:0]   ad;
		logic              nd;
		logic              pd;
		logic [C1_W-1:0]   c1;
		logic              fb;
	} side_t;

	typedef struct packed {
		logic [C1_W-1:0]   rad;
		logic [REM_W-1:0]  rem;
		logic [DATA_W-1:0] root;
		side_t             side;
	} sq_t;

	typedef struct packed {
		logic             neg;
		logic             ovf;
		logic [C3_W-1:0]  den;
		logic [C3_W-1:0]  r;
		logic [QB-1:0]    nb;
		logic [QB-1:0]    q;
	} dv_t;

	typedef struct packed {
		logic [LANES-1:0][DATA_W-1:0] ent;
		logic                         fb;
	} out_t;

endpackage

/* sv/rmj_ifs.sv */
// Handshake interfaces for the state, Jacobian and threshold channels.
interface rmj_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	modport source(output valid, pos_x, pos_y, vel_x, vel_y, input ready);
	modport sink(input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

interface rmj_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] range_dx;
	logic signed [31:0] range_dy;
	logic signed [31:0] bearing_dx;
	logic signed [31:0] bearing_dy;
	logic signed [31:0] rate_dx;
	logic signed [31:0] rate_dy;
	logic               fallback_used;
	modport source(output valid, range_dx, range_dy, bearing_dx, bearing_dy, rate_dx,
		rate_dy, fallback_used, input ready);
	modport sink(input valid, range_dx, range_dy, bearing_dx, bearing_dy, rate_dx,
		rate_dy, fallback_used, output ready);
endinterface

interface rmj_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

/* sv/rmj_sqrt_cell.sv */
// One digit of the integer square root, passing the item on to the next cell.
module rmj_sqrt_cell import rmj_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic src_vld,
	input  sq_t  src,
	output logic dst_vld,
	output sq_t  dst
);

	logic [REM_W+1:0] rem_sh;
	logic [REM_W+1:0] trial;
	logic [REM_W+1:0] diff;
	logic             ge;
	sq_t              nxt;
	logic             vld_q;
	sq_t              data_q;

	always_comb begin
		rem_sh   = {src.rem, src.rad[C1_W-1 -: 2]};
		trial    = {2'b00, src.root, 2'b01};
		diff     = rem_sh - trial;
		ge       = rem_sh >= trial;
		nxt.rad  = {src.rad[C1_W-3:0], 2'b00};
		nxt.rem  = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
		nxt.root = {src.root[DATA_W-2:0], ge};
		nxt.side = src.side;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= src_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	assign dst_vld = vld_q;
	assign dst     = data_q;

endmodule

/* sv/rmj_div_cell.sv */
// One quotient bit of a restoring divider lane, passing the lane to the next cell.
module rmj_div_cell import rmj_pkg::*; (
	input  logic clk,
	input  logic en,
	input  dv_t  src,
	output dv_t  dst
);

	logic [C3_W:0] rs;
	logic [C3_W:0] diff;
	logic          ge;
	dv_t           nxt;
	dv_t           data_q;

	always_comb begin
		rs       = {src.r, src.nb[QB-1]};
		diff     = rs - {1'b0, src.den};
		ge       = rs >= {1'b0, src.den};
		nxt      = src;
		nxt.r    = ge ? diff[C3_W-1:0] : rs[C3_W-1:0];
		nxt.q    = {src.q[QB-2:0], ge};
		nxt.nb   = {src.nb[QB-2:0], 1'b0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	assign dst = data_q;

endmodule

/* sv/radar_measurement_jacobian_core.sv */
// Path of an accepted item to its result: 3 front stages, 32 square root cells, 2 multiply
// stages, divider setup, 33 divider cells, rounding, output buffer.
// Throughput: one item per cycle; the whole chain moves together, gated only by the
// two-entry output buffer, so a new item is taken while one result waits.
// Reset clears all valid bits and the buffer and loads the range threshold with 42950.
module radar_measurement_jacobian_core import rmj_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	rmj_in_if.sink       state,
	rmj_out_if.source    jac,
	rmj_cfg_if.sink      cfg
);

	logic [DATA_W-1:0] thr_q;
	logic              en;
	logic              accept;

	logic                     s1_vld;
	logic signed [DATA_W-1:0] s1_px, s1_py;
	logic [C1_W-1:0]          s1_sqx, s1_sqy;
	logic signed [C1_W-1:0]   s1_pvx, s1_pvy;

	logic                     s2_vld;
	logic [C1_W-1:0]          s2_c1;
	logic signed [C1_W:0]     s2_d;
	logic [DATA_W-1:0]        s2_apx, s2_apy;
	logic                     s2_npx, s2_npy;

	logic                     fb;
	logic [C1_W-1:0]          s2_ad;
	sq_t                      s3_nxt;
	logic                     s3_vld;
	sq_t                      s3;

	logic                     sq_v [SQ_STEPS+1];
	sq_t                      sq_d [SQ_STEPS+1];

	logic                     m1_vld;
	side_t                    m1_side;
	logic [DATA_W-1:0]        m1_c2;
	logic [C1_W-1:0]          m1_c3lo, m1_c3hi, m1_ylo, m1_yhi, m1_xlo, m1_xhi;

	logic                     m2_vld;
	side_t                    m2_side;
	logic [DATA_W-1:0]        m2_c2;
	logic [C3_W-1:0]          m2_c3, m2_yad, m2_xad;

	logic [NUM_W-1:0]         num [LANES];
	logic [C3_W-1:0]          den [LANES];
	logic                     neg [LANES];
	dv_t                      d0_s1 [LANES];
	dv_t                      dv [LANES][QB+1];
	logic [QB:0]              dvv_q;
	logic [QB:0]              dvf_q;

	logic                     rn_vld;
	logic                     rn_fb;
	logic [QB:0]              rn_qr [LANES];
	logic                     rn_neg [LANES];
	logic                     rn_ovf [LANES];

	out_t                     wdat;
	out_t                     fifo_q [2];
	logic [1:0]               cnt_q;
	logic                     wp_q, rp_q;
	logic                     push, pop;

	assign cfg.ready   = 1'b1;
	assign en          = (cnt_q != 2'd2);
	assign state.ready = en;
	assign accept      = state.valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= RANGE_SQ_RESET;
		end else if (cfg.valid) begin
			thr_q <= cfg.data;
		end
	end

	// Front: squares and cross products, then sums, then the near range test.
	always_ff @(posedge clk) begin
		if (en) begin
			s1_px  <= state.pos_x;
			s1_py  <= state.pos_y;
			s1_sqx <= C1_W'(state.pos_x * state.pos_x);
			s1_sqy <= C1_W'(state.pos_y * state.pos_y);
			s1_pvx <= state.vel_x * state.pos_y;
			s1_pvy <= state.vel_y * state.pos_x;

			s2_c1  <= s1_sqx + s1_sqy;
			s2_d   <= s1_pvx - s1_pvy;
			s2_apx <= s1_px[DATA_W-1] ? DATA_W'(-s1_px) : DATA_W'(s1_px);
			s2_apy <= s1_py[DATA_W-1] ? DATA_W'(-s1_py) : DATA_W'(s1_py);
			s2_npx <= s1_px[DATA_W-1];
			s2_npy <= s1_py[DATA_W-1];

			s3 <= s3_nxt;
		end
	end

	always_comb begin
		fb    = (s2_c1 < C1_W'(thr_q)) || (s2_c1 == '0);
		s2_ad = s2_d[C1_W] ? C1_W'(-s2_d) : C1_W'(s2_d);
		s3_nxt.rem       = '0;
		s3_nxt.root      = '0;
		s3_nxt.side.fb   = fb;
		s3_nxt.side.apx  = fb ? FB_MILLI : s2_apx;
		s3_nxt.side.apy  = fb ? FB_CENTI : s2_apy;
		s3_nxt.side.npx  = fb ? 1'b0 : s2_npx;
		s3_nxt.side.npy  = fb ? 1'b0 : s2_npy;
		s3_nxt.side.ad   = fb ? FB_AD : s2_ad;
		s3_nxt.side.nd   = fb ? FB_ND : s2_d[C1_W];
		s3_nxt.side.pd   = fb ? FB_PD : (!s2_d[C1_W] && (s2_d != '0));
		s3_nxt.side.c1   = fb ? FB_C1 : s2_c1;
		s3_nxt.rad       = s3_nxt.side.c1;
	end

	assign sq_v[0] = s3_vld;
	assign sq_d[0] = s3;

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		rmj_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.src_vld (sq_v[k]),
			.src     (sq_d[k]),
			.dst_vld (sq_v[k+1]),
			.dst     (sq_d[k+1])
		);
	end

	// c3 and the rate numerators are 64 by 32 products, split into 32-bit halves.
	always_ff @(posedge clk) begin
		if (en) begin
			m1_side <= sq_d[SQ_STEPS].side;
			m1_c2   <= sq_d[SQ_STEPS].root;
			m1_c3lo <= sq_d[SQ_STEPS].side.c1[31:0] * sq_d[SQ_STEPS].root;
			m1_c3hi <= sq_d[SQ_STEPS].side.c1[63:32] * sq_d[SQ_STEPS].root;
			m1_ylo  <= sq_d[SQ_STEPS].side.apy * sq_d[SQ_STEPS].side.ad[31:0];
			m1_yhi  <= sq_d[SQ_STEPS].side.apy * sq_d[SQ_STEPS].side.ad[63:32];
			m1_xlo  <= sq_d[SQ_STEPS].side.apx * sq_d[SQ_STEPS].side.ad[31:0];
			m1_xhi  <= sq_d[SQ_STEPS].side.apx * sq_d[SQ_STEPS].side.ad[63:32];

			m2_side <= m1_side;
			m2_c2   <= m1_c2;
			m2_c3   <= C3_W'(m1_c3lo) + {m1_c3hi, 32'b0};
			m2_yad  <= C3_W'(m1_ylo) + {m1_yhi, 32'b0};
			m2_xad  <= C3_W'(m1_xlo) + {m1_xhi, 32'b0};
		end
	end

	always_comb begin
		num[L_RDX] = NUM_W'(m2_side.apx) << FRAC_BITS;
		num[L_RDY] = NUM_W'(m2_side.apy) << FRAC_BITS;
		num[L_BDX] = NUM_W'(m2_side.apy) << (2 * FRAC_BITS);
		num[L_BDY] = NUM_W'(m2_side.apx) << (2 * FRAC_BITS);
		num[L_TDX] = NUM_W'(m2_yad) << FRAC_BITS;
		num[L_TDY] = NUM_W'(m2_xad) << FRAC_BITS;
		den[L_RDX] = C3_W'(m2_c2);
		den[L_RDY] = C3_W'(m2_c2);
		den[L_BDX] = C3_W'(m2_side.c1);
		den[L_BDY] = C3_W'(m2_side.c1);
		den[L_TDX] = m2_c3;
		den[L_TDY] = m2_c3;
		neg[L_RDX] = m2_side.npx;
		neg[L_RDY] = m2_side.npy;
		neg[L_BDX] = !m2_side.npy && (m2_side.apy != '0);
		neg[L_BDY] = m2_side.npx;
		neg[L_TDX] = m2_side.npy ^ m2_side.nd;
		neg[L_TDY] = m2_side.npx ^ m2_side.pd;
	end

	// The divider starts from the top bits; a quotient of 2^33 or more is an overflow.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < LANES; j++) begin
				d0_s1[j].neg <= neg[j];
				d0_s1[j].ovf <= C3_W'(num[j][NUM_W-1:QB]) >= den[j];
				d0_s1[j].den <= den[j];
				d0_s1[j].r   <= C3_W'(num[j][NUM_W-1:QB]);
				d0_s1[j].nb  <= num[j][QB-1:0];
				d0_s1[j].q   <= '0;
			end
		end
	end

	for (genvar j = 0; j < LANES; j++) begin : g_lane
		assign dv[j][0] = d0_s1[j];
		for (genvar k = 0; k < QB; k++) begin : g_div
			rmj_div_cell u_cell (
				.clk (clk),
				.en  (en),
				.src (dv[j][k]),
				.dst (dv[j][k+1])
			);
		end
	end

	// Round half away from zero: bump when twice the remainder reaches the divisor.
	always_ff @(posedge clk) begin
		if (en) begin
			rn_fb <= dvf_q[QB];
			for (int j = 0; j < LANES; j++) begin
				rn_qr[j]  <= {1'b0, dv[j][QB].q} +
					(QB+1)'({dv[j][QB].r, 1'b0} >= {1'b0, dv[j][QB].den});
				rn_neg[j] <= dv[j][QB].neg;
				rn_ovf[j] <= dv[j][QB].ovf;
			end
		end
	end

	always_comb begin
		logic [QB:0] lim;
		logic [QB:0] m;
		wdat.fb = rn_fb;
		for (int j = 0; j < LANES; j++) begin
			lim = rn_neg[j] ? (QB+1)'(34'h0_8000_0000) : (QB+1)'(34'h0_7FFF_FFFF);
			m   = (rn_ovf[j] || (rn_qr[j] > lim)) ? lim : rn_qr[j];
			wdat.ent[j] = rn_neg[j] ? DATA_W'(-m) : m[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvf_q <= {dvf_q[QB-1:0], m2_side.fb};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld <= 1'b0;
			s2_vld <= 1'b0;
			s3_vld <= 1'b0;
			m1_vld <= 1'b0;
			m2_vld <= 1'b0;
			dvv_q  <= '0;
			rn_vld <= 1'b0;
		end else if (en) begin
			s1_vld <= accept;
			s2_vld <= s1_vld;
			s3_vld <= s2_vld;
			m1_vld <= sq_v[SQ_STEPS];
			m2_vld <= m1_vld;
			dvv_q  <= {dvv_q[QB-1:0], m2_vld};
			rn_vld <= dvv_q[QB];
		end
	end

	// Two-entry output buffer; the chain stalls only when both entries are full.
	assign push = en && rn_vld;
	assign pop  = jac.valid && jac.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= wdat;
		end
	end

	assign jac.valid         = (cnt_q != 2'd0);
	assign jac.range_dx      = fifo_q[rp_q].ent[L_RDX];
	assign jac.range_dy      = fifo_q[rp_q].ent[L_RDY];
	assign jac.bearing_dx    = fifo_q[rp_q].ent[L_BDX];
	assign jac.bearing_dy    = fifo_q[rp_q].ent[L_BDY];
	assign jac.rate_dx       = fifo_q[rp_q].ent[L_TDX];
	assign jac.rate_dy       = fifo_q[rp_q].ent[L_TDY];
	assign jac.fallback_used = fifo_q[rp_q].fb;

endmodule

/* tb/sv/rmj_jacobian_checker.sv */
// Checker that predicts each Jacobian from accepted states and compares the results.
module rmj_jacobian_checker import rmj_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	rmj_in_if.sink    state_mon,
	rmj_out_if.sink   jac_mon,
	rmj_cfg_if.sink   cfg_mon,
	output int        fail_count,
	output int        pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [DATA_W-1:0] ent [LANES];
		logic              fb;
	} jacobian_t;

	jacobian_t         expected_jacobians[$];
	logic [DATA_W-1:0] range_floor;

	function automatic logic [C1_W-1:0] floor_sqrt(input logic [C1_W-1:0] x);
		logic [C1_W-1:0] res;
		logic [C1_W-1:0] b;
		res = '0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Rounds num/den to nearest with ties away from zero, then saturates to 32 bits.
	function automatic logic [DATA_W-1:0] rounded_ratio(input logic neg,
			input logic [NUM_W-1:0] num, input logic [NUM_W-1:0] den);
		logic [NUM_W-1:0] q;
		logic [NUM_W-1:0] r;
		logic [NUM_W-1:0] lim;
		logic [NUM_W-1:0] m;
		lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
		if (den == 0)
			return lim[DATA_W-1:0];
		q = num / den;
		r = num % den;
		if (r >= den - r)
			q = q + 1;
		m = (q > lim) ? lim : q;
		return neg ? DATA_W'(-m) : m[DATA_W-1:0];
	endfunction

	function automatic jacobian_t predict_jacobian(input logic signed [31:0] sx,
			input logic signed [31:0] sy, input logic signed [31:0] svx,
			input logic signed [31:0] svy);
		jacobian_t j;
		logic signed [63:0] px, py, vx, vy, d;
		logic [C1_W-1:0] c1, c2, apx, apy, ad;
		logic [NUM_W-1:0] c3;
		px = sx; py = sy; vx = svx; vy = svy;
		apx = px < 0 ? -px : px;
		apy = py < 0 ? -py : py;
		c1 = apx * apx + apy * apy;
		j.fb = 1'b0;
		if (c1 < {32'd0, range_floor} || c1 == 0) begin
			j.fb = 1'b1;
			px = 64'(FB_MILLI); py = 64'(FB_CENTI);
			vx = 64'(FB_MILLI); vy = 64'(FB_MILLI);
			apx = px; apy = py;
			c1 = apx * apx + apy * apy;
		end
		c2 = floor_sqrt(c1);
		c3 = NUM_W'(c1) * NUM_W'(c2);
		d = vx * py - vy * px;
		ad = d < 0 ? -d : d;
		j.ent[L_RDX] = rounded_ratio(px < 0, NUM_W'(apx) << FRAC_BITS, NUM_W'(c2));
		j.ent[L_RDY] = rounded_ratio(py < 0, NUM_W'(apy) << FRAC_BITS, NUM_W'(c2));
		j.ent[L_BDX] = rounded_ratio(py > 0, NUM_W'(apy) << (2 * FRAC_BITS), NUM_W'(c1));
		j.ent[L_BDY] = rounded_ratio(px < 0, NUM_W'(apx) << (2 * FRAC_BITS), NUM_W'(c1));
		j.ent[L_TDX] = rounded_ratio((py < 0) != (d < 0),
			(NUM_W'(apy) * NUM_W'(ad)) << FRAC_BITS, c3);
		j.ent[L_TDY] = rounded_ratio((px < 0) != (d > 0),
			(NUM_W'(apx) * NUM_W'(ad)) << FRAC_BITS, c3);
		return j;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		jacobian_t exp_j;
		logic [DATA_W-1:0] got [LANES];
		if (!arst_n) begin
			range_floor <= RANGE_SQ_RESET;
			fail_count <= 0;
			expected_jacobians.delete();
		end else begin
			if (cfg_mon.valid && cfg_mon.ready)
				range_floor <= cfg_mon.data;
			if (state_mon.valid && state_mon.ready)
				expected_jacobians.push_back(predict_jacobian(state_mon.pos_x,
					state_mon.pos_y, state_mon.vel_x, state_mon.vel_y));
			if (jac_mon.valid && jac_mon.ready) begin
				got[L_RDX] = jac_mon.range_dx;   got[L_RDY] = jac_mon.range_dy;
				got[L_BDX] = jac_mon.bearing_dx; got[L_BDY] = jac_mon.bearing_dy;
				got[L_TDX] = jac_mon.rate_dx;    got[L_TDY] = jac_mon.rate_dy;
				if (expected_jacobians.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected Jacobian item", $realtime);
					fail_count <= fail_count + 1;
				end else begin
					exp_j = expected_jacobians.pop_front();
					if (got != exp_j.ent || jac_mon.fallback_used !== exp_j.fb) begin
						if (fail_count < 10)
							$display("%0t: expected %h %h %h %h %h %h fb=%b, got %h %h %h %h %h %h fb=%b",
								$realtime, exp_j.ent[0], exp_j.ent[1], exp_j.ent[2],
								exp_j.ent[3], exp_j.ent[4], exp_j.ent[5], exp_j.fb,
								got[0], got[1], got[2], got[3], got[4], got[5],
								jac_mon.fallback_used);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
		pending_count = expected_jacobians.size();
	end

endmodule

/* tb/sv/radar_measurement_jacobian_core_test.sv */
// Top of the Jacobian testbench: clock, reset, state and threshold stimulus, verdict.
module radar_measurement_jacobian_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIPE_CYCLES = 80;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending_count;
	bit   hold_jacobians;

	rmj_in_if  state_ch();
	rmj_out_if jac_ch();
	rmj_cfg_if cfg_ch();

	radar_measurement_jacobian_core dut (
		.clk(clk), .arst_n(arst_n), .state(state_ch.sink), .jac(jac_ch.source),
		.cfg(cfg_ch.sink)
	);

	rmj_jacobian_checker checker_i (
		.clk(clk), .arst_n(arst_n), .state_mon(state_ch.sink), .jac_mon(jac_ch.sink),
		.cfg_mon(cfg_ch.sink), .fail_count(fail_count), .pending_count(pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// The receiver draws a stall before each item, and pauses long while held.
	initial begin
		int gap;
		jac_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_jacobians) begin
				jac_ch.ready <= 1'b0;
			end else begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
				if (gap > 0) begin
					jac_ch.ready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
				jac_ch.ready <= 1'b1;
				@(posedge clk);
				while (!jac_ch.valid)
					@(posedge clk);
			end
		end
	end

	task automatic send_state(input logic [31:0] px, input logic [31:0] py,
			input logic [31:0] vx, input logic [31:0] vy, input bit idle_gaps);
		int gap;
		gap = idle_gaps ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			state_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		state_ch.valid <= 1'b1;
		state_ch.pos_x <= px; state_ch.pos_y <= py;
		state_ch.vel_x <= vx; state_ch.vel_y <= vy;
		@(posedge clk);
		while (!state_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_range_floor(input logic [31:0] value);
		state_ch.valid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (PIPE_CYCLES) @(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Positions of mixed size, sometimes inside the threshold, sometimes at full range.
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 8) - 4;
			1: return $urandom_range(0, 2000) - 1000;
			2: return $urandom_range(0, 4_000_000) - 2_000_000;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [31:0] edges[8];
		logic [31:0] floors[5];
		edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF,
			32'h0001_0000, 32'hFFFF_0000, 32'h0000_0100};
		floors = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd42950, 32'h0010_0000};
		hold_jacobians = 1'b0;
		state_ch.valid = 1'b0;
		state_ch.pos_x = '0; state_ch.pos_y = '0;
		state_ch.vel_x = '0; state_ch.vel_y = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes, the origin, near range and the register at reset.
		for (int i = 0; i < 8; i++)
			send_state(edges[i], edges[7 - i], edges[(i + 3) % 8], edges[(i + 5) % 8], 1'b0);
		send_state(32'd0, 32'd0, 32'd5, 32'd7, 1'b0);
		send_state(32'd0, 32'd200, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		send_state(32'd207, 32'd0, 32'd1, 32'd1, 1'b0);
		send_state(32'hFFFF_FF31, 32'd1, 32'd1, 32'd1, 1'b0);
		send_state(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);

		// Back pressure: hold the receiver while states keep coming.
		hold_jacobians = 1'b1;
		fork
			begin
				repeat (300) @(negedge clk);
				hold_jacobians = 1'b0;
			end
			for (int i = 0; i < 120; i++)
				send_state(rand_coord(), rand_coord(), $urandom, $urandom, 1'b0);
		join

		for (int phase = 0; phase < 5; phase++) begin
			write_range_floor(phase == 4 ? $urandom : floors[phase]);
			for (int i = 0; i < 130; i++)
				send_state(rand_coord(), rand_coord(), $urandom, $urandom,
					(i % 40) < 25);
		end
		state_ch.valid <= 1'b0;

		while (pending_count != 0)
			@(negedge clk);
		repeat (PIPE_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
